/* rtl/lcfr_pkg.sv */
// Shared types and constants for the length/checksum frame receiver.
package lcfr_pkg;

	typedef enum logic [1:0] {
		PH_LENGTH  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_CHECK   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_SUM   = 2'd1,
		ST_TOO_SHORT = 2'd2
	} status_t;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	localparam logic [7:0] HDR_BYTES = 8'd2;

	localparam int TDATA_W = 32;
	localparam int FIELD_W = 26;

	typedef struct packed {
		logic       valid;
		logic       kind;
		logic [7:0] payload_byte;
		logic [7:0] byte_index;
		status_t    frame_status;
		logic [7:0] payload_count;
	} result_t;

endpackage

/* rtl/length_checksum_frame_receiver.sv */
// Top level of the length-prefixed frame receiver with additive checksum.
//
// Slave stream s_*: one received byte per beat in s_tdata[7:0].
// Master stream m_*: one result beat per payload byte (m_tuser = 0) and one
// per frame end (m_tuser = 1). The first byte of a frame is the total length
// L and gives no beat; L-2 payload bytes follow, then the checksum byte,
// which must equal the 8-bit sum of L and the payload.
// Datapath: input register, parser logic, output register. A byte in the input
// register loads its result beat into the free output register (m_tvalid high).
// Throughput is one byte per cycle while m_tready stays high. While a
// finished beat waits in the output register, the input register still takes
// one byte; a length byte gives no beat and passes the parser even then.
// The input stage holds once both registers carry pending beats.
// Reset clears the frame state to awaiting a length byte and empties both
// registers. When m_tready is low, s_tready falls after the input and
// output registers fill; no beat is dropped or repeated.
module length_checksum_frame_receiver (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,  // [7:0] rx_byte
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [lcfr_pkg::TDATA_W-1:0] m_tdata,  // payload_byte, byte_index,
	                                               // frame_status, payload_count
	output logic                         m_tuser   // kind
);
	import lcfr_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       step;
	logic       valid_q;
	logic       kind_q;
	logic [FIELD_W-1:0] data_q;
	result_t    res;

	assign out_free = !valid_q || m_tready;
	assign step     = valid_s1 && (out_free || !res.valid);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			byte_s1 <= s_tdata;
	end

	lcfr_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (out_free)
			valid_q <= step && res.valid;
	end

	always_ff @(posedge clk) begin
		if (out_free && step && res.valid) begin
			kind_q <= res.kind;
			data_q <= {res.payload_count, res.frame_status, res.byte_index, res.payload_byte};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {{(TDATA_W - FIELD_W){1'b0}}, data_q};

endmodule

/* rtl/lcfr_parse.sv */
// Frame parser: phase state machine, remaining count, running sum, result decode.
module lcfr_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	output lcfr_pkg::result_t res
);
	import lcfr_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] remaining_q, remaining_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] len_q, len_d;
	logic [7:0] total;

	assign total = len_q - HDR_BYTES;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LENGTH;
			remaining_q <= '0;
			sum_q       <= '0;
			len_q       <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			sum_q       <= sum_d;
			len_q       <= len_d;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		sum_d       = sum_q;
		len_d       = len_q;
		res         = '0;
		case (phase_q)
			PH_PAYLOAD: begin
				res.valid        = 1'b1;
				res.kind         = KIND_PAYLOAD;
				res.payload_byte = rx_byte;
				res.byte_index   = total - remaining_q;
				sum_d            = sum_q + rx_byte;
				remaining_d      = remaining_q - 8'd1;
				if (remaining_d == '0)
					phase_d = PH_CHECK;
			end
			PH_CHECK: begin
				res.valid = 1'b1;
				res.kind  = KIND_END;
				if (len_q <= HDR_BYTES) begin
					res.frame_status = ST_TOO_SHORT;
				end else begin
					res.frame_status  = (sum_q == rx_byte) ? ST_OK : ST_BAD_SUM;
					res.payload_count = total;
				end
				phase_d     = PH_LENGTH;
				remaining_d = '0;
			end
			default: begin
				len_d = rx_byte;
				sum_d = rx_byte;
				if (rx_byte > HDR_BYTES) begin
					remaining_d = rx_byte - HDR_BYTES;
					phase_d     = PH_PAYLOAD;
				end else begin
					remaining_d = '0;
					phase_d     = PH_CHECK;
				end
			end
		endcase
	end

endmodule

/* tb/length_checksum_frame_receiver_checker.sv */
// Checker for the frame receiver: predicts every result beat and compares it to the output.
module length_checksum_frame_receiver_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [7:0]                   s_tdata,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [lcfr_pkg::TDATA_W-1:0] m_tdata,
	input  logic                         m_tuser,
	output int                           errors,
	output int                           pending
);
	import lcfr_pkg::*;

	typedef struct {
		logic       kind;
		logic [7:0] pbyte;
		logic [7:0] idx;
		status_t    status;
		logic [7:0] count;
	} frame_beat_t;

	frame_beat_t beat_q[$];

	phase_t     ph;
	logic [7:0] left;
	logic [7:0] sum;
	logic [7:0] flen;

	initial begin
		errors = 0;
		pending = 0;
	end

	task automatic report(input string what, input int got, input int exp);
		if (errors < 30) begin
			$display("ERROR %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, exp);
		end
		errors++;
	endtask

	// advance the frame parser by one received byte
	task automatic parse_byte(input logic [7:0] b);
		frame_beat_t r;
		case (ph)
			PH_PAYLOAD: begin
				r.kind   = KIND_PAYLOAD;
				r.pbyte  = b;
				r.idx    = (flen - HDR_BYTES) - left;
				r.status = ST_OK;
				r.count  = 8'd0;
				beat_q.insert(beat_q.size(), r);
				sum  = sum + b;
				left = left - 8'd1;
				if (left == 8'd0) begin
					ph = PH_CHECK;
				end
			end
			PH_CHECK: begin
				r.kind  = KIND_END;
				r.pbyte = 8'd0;
				r.idx   = 8'd0;
				if (flen <= HDR_BYTES) begin
					r.status = ST_TOO_SHORT;
					r.count  = 8'd0;
				end else begin
					r.status = (sum == b) ? ST_OK : ST_BAD_SUM;
					r.count  = flen - HDR_BYTES;
				end
				beat_q.insert(beat_q.size(), r);
				ph   = PH_LENGTH;
				left = 8'd0;
			end
			default: begin
				flen = b;
				sum  = b;
				if (b > HDR_BYTES) begin
					left = b - HDR_BYTES;
					ph   = PH_PAYLOAD;
				end else begin
					left = 8'd0;
					ph   = PH_CHECK;
				end
			end
		endcase
	endtask

	task automatic check_beat();
		frame_beat_t e;
		if (beat_q.size() == 0) begin
			report("result beat with none pending, tdata", m_tdata, 0);
		end else begin
			e = beat_q.pop_front();
			if (m_tuser !== e.kind)
				report("kind", 32'(m_tuser), 32'(e.kind));
			if (m_tdata[7:0] !== e.pbyte)
				report("payload_byte", 32'(m_tdata[7:0]), 32'(e.pbyte));
			if (m_tdata[15:8] !== e.idx)
				report("byte_index", 32'(m_tdata[15:8]), 32'(e.idx));
			if (m_tdata[17:16] !== e.status)
				report("frame_status", 32'(m_tdata[17:16]), 32'(e.status));
			if (m_tdata[25:18] !== e.count)
				report("payload_count", 32'(m_tdata[25:18]), 32'(e.count));
			if (m_tdata[TDATA_W-1:FIELD_W] !== '0)
				report("tdata padding", 32'(m_tdata[TDATA_W-1:FIELD_W]), 0);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph   = PH_LENGTH;
			left = 8'd0;
			sum  = 8'd0;
			flen = 8'd0;
			beat_q.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_beat();
			end
			if (s_tvalid && s_tready) begin
				parse_byte(s_tdata);
			end
			pending <= beat_q.size();
		end
	end

endmodule

/* tb/length_checksum_frame_receiver_tb.sv */
// Testbench top for the frame receiver: clock, reset, byte stimulus, output stalls, verdict.
module length_checksum_frame_receiver_tb;
	import lcfr_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [TDATA_W-1:0]  m_tdata;
	logic                m_tuser;
	int                  errors;
	int                  pending;

	int                  sent_cnt;
	int                  burst_left;
	bit                  offering;

	length_checksum_frame_receiver i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	length_checksum_frame_receiver_checker i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.errors   (errors),
		.pending  (pending)
	);

	initial clk = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#(12 * 300000);
		$display("DONE: errors detected");
		$finish;
	end

	// offer one byte and hold it until taken; bursts end with a random gap, which may be zero
	task automatic send_byte(input logic [7:0] b);
		int gap;
		s_tdata  <= b;
		s_tvalid <= 1'b1;
		offering = 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_cnt++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				offering = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain_results();
		if (offering) begin
			s_tvalid <= 1'b0;
			offering = 1'b0;
		end
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic send_frame(input logic [7:0] len, input bit good_sum);
		logic [7:0] sum;
		logic [7:0] p;
		sum = len;
		send_byte(len);
		if (len > HDR_BYTES) begin
			for (int i = 0; i < int'(len - HDR_BYTES); i++) begin
				p = 8'($urandom_range(0, 255));
				sum = sum + p;
				send_byte(p);
			end
		end
		if (good_sum || len <= HDR_BYTES)
			send_byte(good_sum ? sum : 8'($urandom_range(0, 255)));
		else
			send_byte(sum ^ 8'($urandom_range(1, 255)));
	endtask

	// output side: one long hold-off right after reset, then mixed stall patterns
	initial begin
		int mode;
		int len;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		repeat (80) @(posedge clk);
		forever begin
			mode = $urandom_range(0, 9);
			len = $urandom_range(10, 60);
			for (int i = 0; i < len; i++) begin
				case (mode)
					0, 1, 2: m_tready <= 1'b1;
					3, 4, 5: m_tready <= ($urandom_range(0, 1) == 0);
					6, 7:    m_tready <= ((i % 5) < 3);
					8:       m_tready <= ($urandom_range(0, 7) == 0);
					default: m_tready <= (i >= len - 3);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		int sel;
		int r;
		logic [7:0] len;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = 8'd0;
		sent_cnt   = 0;
		burst_left = 0;
		offering   = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// too short frames, checksum wraparound, good and bad sums
		send_byte(8'd0);   send_byte(8'h00);
		send_byte(8'd1);   send_byte(8'hff);
		send_byte(8'd2);   send_byte(8'h5a);
		send_byte(8'd3);   send_byte(8'hff); send_byte(8'h02);
		send_byte(8'd3);   send_byte(8'h00); send_byte(8'h04);
		send_byte(8'd4);   send_byte(8'haa); send_byte(8'h55); send_byte(8'h03);
		send_byte(8'd5);   send_byte(8'h80); send_byte(8'h01); send_byte(8'h7f);
		send_byte(8'h06);
		drain_results();

		// longest frame: byte_index reaches its maximum
		send_frame(8'd255, 1'b1);

		while (sent_cnt < 800) begin
			sel = $urandom_range(0, 99);
			if (sel < 8) begin
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
			end else begin
				r = $urandom_range(0, 99);
				if (r < 12)
					len = 8'($urandom_range(0, 2));
				else if (r < 96)
					len = 8'($urandom_range(3, 24));
				else
					len = 8'($urandom_range(25, 255));
				send_frame(len, $urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 59) == 0) begin
				drain_results();
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
